FILE: sv/brb_pkg.sv
// Shared types, codes and constants of the byte ring buffer.
package brb_pkg;

  localparam int DATA_W    = 8;
  localparam int CNT_W     = 6;
  localparam int FILL_W    = 6;
  localparam int DEPTH_DEF = 64;

  // Function codes carried by a request
  typedef enum logic [2:0] {
    FUNC_WRITE   = 3'd0,
    FUNC_READ    = 3'd1,
    FUNC_PEEK    = 3'd2,
    FUNC_DISCARD = 3'd3,
    FUNC_CLEAR   = 3'd4
  } func_e;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_REJECT   = 2'd1,
    STAT_EMPTY    = 2'd2,
    STAT_BAD_DISC = 2'd3
  } status_e;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_STREAM = 2'b10
  } state_e;

  // One result item
  typedef struct packed {
    logic [DATA_W-1:0] byte_val;
    logic              last;
    status_e           status;
    logic [FILL_W-1:0] fill;
  } result_t;

endpackage

FILE: sv/brb_outq.sv
// Two-entry result queue that decouples the buffer core from the receiver.
module brb_outq import brb_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  result_t push_data_i,
  input  logic    pop_i,
  output logic    valid_o,
  output result_t data_o,
  output logic [1:0] cnt_o
);

  result_t    ent_q [2];
  result_t    ent_d [2];
  logic [1:0] cnt_q, cnt_d;
  logic       pop;

  assign valid_o = (cnt_q != 2'd0);
  assign pop     = pop_i & valid_o;
  assign data_o  = ent_q[0];
  assign cnt_o   = cnt_q;

  // Shift towards the head on pop, append at the tail on push
  always_comb begin
    ent_d[0] = ent_q[0];
    ent_d[1] = ent_q[1];
    cnt_d    = cnt_q;
    case ({push_i, pop})
      2'b01: begin
        ent_d[0] = ent_q[1];
        cnt_d    = cnt_q - 2'd1;
      end
      2'b10: begin
        if (cnt_q == 2'd0) begin
          ent_d[0] = push_data_i;
        end else begin
          ent_d[1] = push_data_i;
        end
        cnt_d = cnt_q + 2'd1;
      end
      2'b11: begin
        if (cnt_q == 2'd1) begin
          ent_d[0] = push_data_i;
        end else begin
          ent_d[0] = ent_q[1];
          ent_d[1] = push_data_i;
        end
      end
      default: begin
      end
    endcase
  end

  // Hold the entry payload
  always_ff @(posedge clk_i) begin
    ent_q[0] <= ent_d[0];
    ent_q[1] <= ent_d[1];
  end

  // Track occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

endmodule

FILE: sv/byte_ring_buffer_peek_discard.sv
// Top level of the byte ring buffer with peek and discard.
//
// Requests arrive on in_valid_i/in_ready_o with func_i, data_i, count_i and
// first_i; results leave on out_valid_o/out_ready_i with byte_out_o, last_o,
// status_o and fill_level_o. The ring holds at most DEPTH-1 bytes.
// Write, discard, clear and empty read/peek requests give one result, which
// sits in the output queue in the cycle after the request is taken; one such
// request can be taken every cycle while the queue has room.
// A read or peek of N bytes streams the bytes out of the ring memory through
// its single read port: each byte is fetched into a registered read stage and
// then pushed into the result queue, one byte per cycle while the queue has
// room, and the block takes the next request once the last byte has left the
// memory.
// Reset empties the buffer and the result queue; the ring contents are not
// cleared. When the receiver stalls, the two-entry result queue fills, byte
// fetches pause and in_ready_o drops until there is room again.
module byte_ring_buffer_peek_discard import brb_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [2:0]        func_i,
  input  logic [DATA_W-1:0] data_i,
  input  logic [CNT_W-1:0]  count_i,
  input  logic              first_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [DATA_W-1:0] byte_out_o,
  output logic              last_o,
  output logic [1:0]        status_o,
  output logic [FILL_W-1:0] fill_level_o
);

  localparam int         PW     = (DEPTH > 2) ? $clog2(DEPTH) : 1;
  localparam logic [6:0] DEPTH7 = 7'(DEPTH);

  // Ring memory
  logic [DATA_W-1:0] ring_mem [DEPTH];
  logic [DATA_W-1:0] rd_data_q;

  state_e            state_q, state_d;
  logic [PW-1:0]     wp_q, wp_d, rp_q, rp_d;
  logic [CNT_W-1:0]  run_rem_q, run_rem_d;
  logic              run_acc_q, run_acc_d;
  logic [PW-1:0]     rd_addr_q, rd_addr_d;
  logic [FILL_W-1:0] rd_left_q, rd_left_d;
  logic [FILL_W-1:0] rd_fill_q, rd_fill_d;
  logic              rd_pend_q, rd_pend_last_q;

  logic              in_acc, pop, issue, mem_we, res_push, q_push;
  logic [1:0]        q_cnt;
  logic [2:0]        occ;
  logic [6:0]        wp7, rp7, fill7, wr_len, space7;
  logic [FILL_W-1:0] fill, rd_len;
  result_t           res, q_data, q_head;

  function automatic logic [PW-1:0] ptr_add(input logic [PW-1:0] p, input logic [6:0] n);
    logic [7:0] s;
    s = 8'(p) + 8'(n);
    if (s >= 8'(DEPTH)) begin
      s = s - 8'(DEPTH);
    end
    return s[PW-1:0];
  endfunction

  assign in_ready_o = (state_q == ST_IDLE) && !rd_pend_q && (q_cnt != 2'd2);
  assign in_acc     = in_valid_i & in_ready_o;
  assign pop        = out_valid_o & out_ready_i;

  // Current fill and derived lengths
  assign wp7    = 7'(wp_q);
  assign rp7    = 7'(rp_q);
  assign fill7  = (wp7 >= rp7) ? (wp7 - rp7) : (DEPTH7 - rp7 + wp7);
  assign fill   = fill7[FILL_W-1:0];
  assign wr_len = (7'(count_i) > DEPTH7) ? DEPTH7 : 7'(count_i);
  assign space7 = DEPTH7 - 7'd1 - fill7;
  assign rd_len = ((count_i == '0) || (count_i > fill)) ? fill : count_i;

  // Fetch a byte when the queue will have room for it on return
  assign occ   = 3'(q_cnt) + 3'(rd_pend_q) - 3'(pop);
  assign issue = (state_q == ST_STREAM) && (occ <= 3'd1);

  // Decode a request and advance the fetch sequencer
  always_comb begin
    state_d   = state_q;
    wp_d      = wp_q;
    rp_d      = rp_q;
    run_rem_d = run_rem_q;
    run_acc_d = run_acc_q;
    rd_addr_d = rd_addr_q;
    rd_left_d = rd_left_q;
    rd_fill_d = rd_fill_q;
    mem_we    = 1'b0;
    res_push  = 1'b0;
    res       = '0;
    res.last  = 1'b1;
    res.status = STAT_OK;

    if (in_acc) begin
      case (func_e'(func_i))
        FUNC_WRITE: begin
          res_push = 1'b1;
          if (first_i) begin
            if ((wr_len == 7'd0) || (wr_len > space7)) begin
              run_acc_d  = 1'b0;
              run_rem_d  = '0;
              res.status = STAT_REJECT;
            end else begin
              run_acc_d = 1'b1;
              run_rem_d = wr_len[CNT_W-1:0] - CNT_W'(1);
              mem_we    = 1'b1;
              wp_d      = ptr_add(wp_q, 7'd1);
            end
          end else if (run_acc_q && (run_rem_q != '0)) begin
            run_rem_d = run_rem_q - CNT_W'(1);
            mem_we    = 1'b1;
            wp_d      = ptr_add(wp_q, 7'd1);
          end else begin
            res.status = STAT_REJECT;
          end
          res.fill = fill + FILL_W'(mem_we);
        end
        FUNC_READ, FUNC_PEEK: begin
          if (rd_len == '0) begin
            res_push   = 1'b1;
            res.status = STAT_EMPTY;
            res.fill   = fill;
          end else begin
            state_d   = ST_STREAM;
            rd_addr_d = rp_q;
            rd_left_d = rd_len;
            if (func_e'(func_i) == FUNC_READ) begin
              rp_d      = ptr_add(rp_q, 7'(rd_len));
              rd_fill_d = fill - rd_len;
            end else begin
              rd_fill_d = fill;
            end
          end
        end
        FUNC_DISCARD: begin
          res_push = 1'b1;
          if (count_i > fill) begin
            wp_d       = '0;
            rp_d       = '0;
            res.status = STAT_BAD_DISC;
            res.fill   = '0;
          end else begin
            rp_d     = ptr_add(rp_q, 7'(count_i));
            res.fill = fill - count_i;
          end
        end
        FUNC_CLEAR: begin
          res_push = 1'b1;
          wp_d     = '0;
          rp_d     = '0;
          res.fill = '0;
        end
        default: begin
        end
      endcase
    end

    if (issue) begin
      rd_left_d = rd_left_q - FILL_W'(1);
      rd_addr_d = (32'(rd_addr_q) == DEPTH - 1) ? '0 : rd_addr_q + PW'(1);
      if (rd_left_q == FILL_W'(1)) begin
        state_d = ST_IDLE;
      end
    end
  end

  // Store bytes and fetch into a registered read-data stage
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      ring_mem[wp_q] <= data_i;
    end
    if (issue) begin
      rd_data_q <= ring_mem[rd_addr_q];
    end
  end

  // Hold fetch bookkeeping
  always_ff @(posedge clk_i) begin
    rd_addr_q <= rd_addr_d;
    rd_fill_q <= rd_fill_d;
    if (issue) begin
      rd_pend_last_q <= (rd_left_q == FILL_W'(1));
    end
  end

  // Advance control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      wp_q      <= '0;
      rp_q      <= '0;
      run_rem_q <= '0;
      run_acc_q <= 1'b0;
      rd_left_q <= '0;
      rd_pend_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      wp_q      <= wp_d;
      rp_q      <= rp_d;
      run_rem_q <= run_rem_d;
      run_acc_q <= run_acc_d;
      rd_left_q <= rd_left_d;
      rd_pend_q <= issue;
    end
  end

  // Merge fetched bytes and direct results into the queue
  always_comb begin
    q_data = res;
    if (rd_pend_q) begin
      q_data.byte_val = rd_data_q;
      q_data.last     = rd_pend_last_q;
      q_data.status   = STAT_OK;
      q_data.fill     = rd_fill_q;
    end
  end
  assign q_push = res_push | rd_pend_q;

  brb_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_data),
    .pop_i       (out_ready_i),
    .valid_o     (out_valid_o),
    .data_o      (q_head),
    .cnt_o       (q_cnt)
  );

  assign byte_out_o   = q_head.byte_val;
  assign last_o       = q_head.last;
  assign status_o     = q_head.status;
  assign fill_level_o = q_head.fill;

`ifndef SYNTHESIS
  // A direct result never collides with a returning byte
  assert property (@(posedge clk_i) disable iff (!rst_ni) res_push |-> !rd_pend_q)
    else $error("direct result collides with fetched byte");
  // The result queue never overflows
  assert property (@(posedge clk_i) disable iff (!rst_ni) (q_push && q_cnt == 2'd2) |-> pop)
    else $error("result queue overflow");
  // Streaming always has bytes left to fetch
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (state_q == ST_STREAM) |-> (rd_left_q != '0))
    else $error("stream with nothing left");
  // A fetch is followed by a push of its byte
  assert property (@(posedge clk_i) disable iff (!rst_ni) issue |=> q_push)
    else $error("fetched byte not queued");
`endif

endmodule
